>>> rtl/chacha8_xorshift_stream_decrypt_assert.svh
// Assertion macros for the stream decryptor checker.
`ifndef CHACHA8_XORSHIFT_STREAM_DECRYPT_ASSERT_SVH
`define CHACHA8_XORSHIFT_STREAM_DECRYPT_ASSERT_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define CXS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the following cycle.
`define CXS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/cxs_pkg.sv
// ----------------------------------------------------------------------------
// cxs_pkg
// Shared types and constants for the ChaCha-seeded xorshift decryptor.
// ----------------------------------------------------------------------------
package cxs_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [31:0] ALL_ONES = 32'hffffffff;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;
  localparam logic [2:0] REG_SEED = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_XOR,
    ST_OUT
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction
endpackage

>>> rtl/cxs_qround.sv
// ----------------------------------------------------------------------------
// cxs_qround
// Shared ChaCha quarter-round unit, one quarter round per cycle.
// ----------------------------------------------------------------------------
module cxs_qround (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);
  import cxs_pkg::*;
  logic [31:0] a1, b1, c1, d1, a2, c2, d2;
  always_comb begin
    a1 = a + b;
    d1 = rotl(d ^ a1, 16);
    c1 = c + d1;
    b1 = rotl(b ^ c1, 12);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    a_out = a2;
    d_out = d2;
    c_out = c2;
    b_out = rotl(b1 ^ c2, 7);
  end
endmodule

>>> rtl/chacha8_xorshift_stream_decrypt.sv
// ----------------------------------------------------------------------------
// chacha8_xorshift_stream_decrypt
// Byte stream decryptor: payload XOR a ChaCha-seeded xorshift keystream.
// ----------------------------------------------------------------------------
// A byte at the first position of a chunk passes through the states LOAD,
// ROUND, FINAL and XOR before its result is shown in OUT: the single shared
// quarter-round unit runs eight quarter rounds per double round, one per
// cycle. Any other byte goes from LOAD straight to XOR and then OUT. Results
// leave through a one-beat output register; the block takes no new byte
// until that result has been taken and the state is back in IDLE.
// No clearing pass after reset.
module chacha8_xorshift_stream_decrypt #(
  parameter int CHUNK_BYTES = 1024,
  parameter int DOUBLE_ROUNDS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  cipher_byte,
  input  logic        message_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  plain_byte
);
  import cxs_pkg::*;
  localparam int PW = $clog2(CHUNK_BYTES);
  localparam int RW = $clog2(DOUBLE_ROUNDS * 8 + 1);

  logic [63:0] key [4];
  logic [31:0] nonce, seed;
  logic [63:0] counter;
  logic [PW-1:0] position;
  logic [31:0] win [16];
  logic [31:0] w [16];
  logic [7:0] cbyte;
  logic [RW-1:0] qcount;
  state_t state, state_next;
  logic [31:0] qa, qb, qc, qd, ra, rb, rc, rd;
  logic [3:0] ia, ib, ic, id;
  logic [PW-1:0] p_eff;
  logic [3:0] slot;
  logic [31:0] xs, xs1, xs2, fb;

  cxs_qround u_qround (
    .a(qa), .b(qb), .c(qc), .d(qd),
    .a_out(ra), .b_out(rb), .c_out(rc), .d_out(rd)
  );

  always_comb begin
    logic [1:0] col;
    col = qcount[1:0];
    if (!qcount[2]) begin
      ia = {2'b00, col};
      ib = {2'b01, col};
      ic = {2'b10, col};
      id = {2'b11, col};
    end else begin
      ia = {2'b00, col};
      ib = {2'b01, col + 2'd1};
      ic = {2'b10, col + 2'd2};
      id = {2'b11, col + 2'd3};
    end
    qa = w[ia];
    qb = w[ib];
    qc = w[ic];
    qd = w[id];
  end

  assign slot = position[5:2];
  always_comb begin
    xs1 = win[slot] ^ (win[slot] << 13);
    xs2 = xs1 ^ (xs1 >> 17);
    xs = xs2 ^ (xs2 << 5);
    fb = seed ^ nonce;
    if (fb == '0) fb = (seed != '0) ? seed : ALL_ONES;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (position == '0) state_next = ST_ROUND;
        else state_next = ST_XOR;
      end
      ST_ROUND: if (qcount == RW'(DOUBLE_ROUNDS * 8 - 1)) state_next = ST_FINAL;
      ST_FINAL: state_next = ST_XOR;
      ST_XOR: state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  assign p_eff = message_start ? '0 : position;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      counter <= '0;
      position <= '0;
      qcount <= '0;
      for (int i = 0; i < 4; i++) key[i] <= '0;
      nonce <= '0;
      seed <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0: key[0] <= cfg_data;
          REG_KEY1: key[1] <= cfg_data;
          REG_KEY2: key[2] <= cfg_data;
          REG_KEY3: key[3] <= cfg_data;
          REG_NONCE: nonce <= cfg_data[31:0];
          REG_SEED: seed <= cfg_data[31:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_valid) begin
          cbyte <= cipher_byte;
          position <= p_eff;
          if (message_start) counter <= '0;
        end
        ST_LOAD: begin
          qcount <= '0;
          w[0] <= SIGMA0; w[1] <= SIGMA1; w[2] <= SIGMA2; w[3] <= SIGMA3;
          for (int i = 0; i < 4; i++) begin
            w[4 + 2 * i] <= key[i][31:0];
            w[5 + 2 * i] <= key[i][63:32];
          end
          w[12] <= counter[31:0];
          w[13] <= counter[63:32];
          w[14] <= nonce;
          w[15] <= seed;
          if ({1'b0, position} >= (PW + 1)'(64) && position[1:0] == 2'd0)
            win[slot] <= (xs == '0) ? fb : xs;
        end
        ST_ROUND: begin
          w[ia] <= ra; w[ib] <= rb; w[ic] <= rc; w[id] <= rd;
          qcount <= qcount + RW'(1);
        end
        ST_FINAL: begin
          win[0] <= w[0] + SIGMA0; win[1] <= w[1] + SIGMA1;
          win[2] <= w[2] + SIGMA2; win[3] <= w[3] + SIGMA3;
          for (int i = 0; i < 4; i++) begin
            win[4 + 2 * i] <= w[4 + 2 * i] + key[i][31:0];
            win[5 + 2 * i] <= w[5 + 2 * i] + key[i][63:32];
          end
          win[12] <= w[12] + counter[31:0];
          win[13] <= w[13] + counter[63:32];
          win[14] <= w[14] + nonce;
          win[15] <= w[15] + seed;
        end
        ST_XOR: begin
          plain_byte <= cbyte ^ 8'(win[slot] >> {position[1:0], 3'b000});
          if ({1'b0, position} == (PW + 1)'(CHUNK_BYTES - 1)) begin
            position <= '0;
            counter <= counter + 64'd1;
          end else begin
            position <= position + PW'(1);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/cxs_checker.sv
// ----------------------------------------------------------------------------
// cxs_checker
// Port-level checks for the stream decryptor, bound to the top level.
// ----------------------------------------------------------------------------
`include "chacha8_xorshift_stream_decrypt_assert.svh"
module cxs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] plain_byte
);
  `CXS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(plain_byte))
  `CXS_ASSERT_SAME(a_one_side, out_valid, !in_ready)
  `CXS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CXS_ASSERT_NEXT(a_drained, out_valid && out_ready, !out_valid)
endmodule

bind chacha8_xorshift_stream_decrypt cxs_checker u_cxs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .plain_byte(plain_byte)
);

>>> test/chacha8_xorshift_stream_decrypt_checker.sv
// ----------------------------------------------------------------------------
// chacha8_xorshift_stream_decrypt_checker
// Watches the byte channels and the register port, computes the expected
// plaintext with its own ChaCha and xorshift keystream, and counts mismatches.
// ----------------------------------------------------------------------------
module chacha8_xorshift_stream_decrypt_checker #(
  parameter int CHUNK_BYTES = 1024,
  parameter int DOUBLE_ROUNDS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  cipher_byte,
  input  logic        message_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  plain_byte,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cxs_pkg::*;

  logic [63:0] key_pair [4];
  logic [31:0] nonce, seed;
  logic [63:0] chunk_count;
  int unsigned byte_pos;
  logic [31:0] window [16];
  logic [7:0] plain_fifo [$];

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic qround(inout logic [31:0] s [16], input int a, b, c, d);
    s[a] += s[b]; s[d] = rol(s[d] ^ s[a], 16);
    s[c] += s[d]; s[b] = rol(s[b] ^ s[c], 12);
    s[a] += s[b]; s[d] = rol(s[d] ^ s[a], 8);
    s[c] += s[d]; s[b] = rol(s[b] ^ s[c], 7);
  endtask

  task automatic chacha_fill();
    logic [31:0] init [16];
    logic [31:0] w [16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_pair[i][31:0];
      init[5 + 2 * i] = key_pair[i][63:32];
    end
    init[12] = chunk_count[31:0];
    init[13] = chunk_count[63:32];
    init[14] = nonce;
    init[15] = seed;
    w = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
      qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
      qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
      qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) window[i] = w[i] + init[i];
  endtask

  function automatic logic [31:0] xorshift_word(logic [31:0] v);
    logic [31:0] fb;
    v ^= v << 13;
    v ^= v >> 17;
    v ^= v << 5;
    if (v == 0) begin
      fb = seed ^ nonce;
      if (fb == 0) fb = (seed != 0) ? seed : ALL_ONES;
      v = fb;
    end
    return v;
  endfunction

  task automatic decrypt_byte(input logic [7:0] cb, input logic first);
    int slot;
    logic [7:0] expect_byte;
    if (first) begin
      chunk_count = 0;
      byte_pos = 0;
    end
    slot = (byte_pos >> 2) & 15;
    if (byte_pos == 0) chacha_fill();
    else if (byte_pos >= 64 && byte_pos % 4 == 0) window[slot] = xorshift_word(window[slot]);
    expect_byte = cb ^ window[slot][8 * (byte_pos % 4) +: 8];
    plain_fifo = {plain_fifo, expect_byte};
    byte_pos++;
    if (byte_pos >= CHUNK_BYTES) begin
      byte_pos = 0;
      chunk_count++;
    end
  endtask

  assign pending = plain_fifo.size();

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      for (int i = 0; i < 4; i++) key_pair[i] = '0;
      nonce = '0;
      seed = '0;
      chunk_count = '0;
      byte_pos = 0;
      plain_fifo.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_pair[cfg_index[1:0]] = cfg_data;
          REG_NONCE: nonce = cfg_data[31:0];
          REG_SEED: seed = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decrypt_byte(cipher_byte, message_start);
      if (out_valid && out_ready) begin
        if (plain_fifo.size() == 0) begin
          $display("%0t: unexpected beat plain_byte=%h", $time, plain_byte);
          errors++;
        end else begin
          want = plain_fifo.pop_front();
          if (plain_byte !== want) begin
            $display("%0t: plain_byte expected %h actual %h", $time, want, plain_byte);
            errors++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives byte beats and register writes into the stream decryptor with random
// gaps and output stalls, across several key settings, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cxs_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_KEY0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [7:0] cipher_byte = '0;
  logic message_start = 0;
  logic out_valid, out_ready = 0;
  logic [7:0] plain_byte;
  int errors, pending, cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  chacha8_xorshift_stream_decrypt dut (.*);
  chacha8_xorshift_stream_decrypt_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stall the output side at random
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    cipher_byte <= b;
    message_start <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic load_keys(input int mode);
    logic [63:0] v;
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      write_reg(3'(i), v);
    end
  endtask

  task automatic run_message(input int len, input bit busy);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), i == 0, busy ? 0 : $urandom_range(0, 4));
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // reset keys; extreme bytes; restart mid-chunk
    send_byte(8'h00, 1, 0);
    send_byte(8'hff, 0, 0);
    send_byte(8'h55, 0, 1);
    send_byte(8'haa, 1, 0);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom), 0, 0);
    drain();
    // all ones keys, across a chunk boundary back to back
    load_keys(1);
    end_writes();
    run_message(1100, 1);
    drain();
    // zero keys: xorshift fallback path with seed and nonce equal
    load_keys(0);
    write_reg(REG_SEED, 64'h0000_0000_dead_beef);
    write_reg(REG_NONCE, 64'h0000_0000_dead_beef);
    end_writes();
    run_message(200, 0);
    drain();
    for (int p = 0; p < 3; p++) begin
      load_keys(2);
      end_writes();
      run_message($urandom_range(40, 200), p[0]);
      run_message($urandom_range(1, 80), 0);
      drain();
    end
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/cxs_pkg.sv
rtl/cxs_qround.sv
rtl/chacha8_xorshift_stream_decrypt.sv
rtl/cxs_checker.sv
test/chacha8_xorshift_stream_decrypt_checker.sv
test/tb_top.sv
